[design/tria_pkg.sv]
// shared types and codes for the two-resource interval assigner
package tria_pkg;

   localparam logic       MODE_LOAD    = 1'b0;
   localparam logic       MODE_READ    = 1'b1;
   localparam logic       KIND_VERDICT = 1'b0;
   localparam logic       KIND_READ    = 1'b1;
   localparam logic [1:0] OWNER_FIRST  = 2'd0;
   localparam logic [1:0] OWNER_SECOND = 2'd1;
   localparam logic [1:0] OWNER_NONE   = 2'd2;

   typedef struct packed {
      logic load;
      logic read_issue;
      logic scan_init;
      logic scan_issue;
      logic commit_assign;
      logic next_resource;
      logic emit_verdict;
      logic emit_read;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic found;
      logic second;
      logic out_free;
   } status_type;

endpackage

[design/two_resource_interval_assigner.sv]
// top level of the two-resource greedy interval assigner
// a load word is stored as it is accepted; a read fetches the owner on acceptance
// and the read state registers the answer once the output is free; no new request
// is taken until then; after the last interval each pick is one scan over the set,
// so the verdict follows after assigned + 2 scans
// sync reset clears counters, flags and the result valid flag; stores need no clearing
module two_resource_interval_assigner #(
   parameter int MAX_INTERVALS = 1024,
   parameter int TIME_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_interval_start,
   input  logic [15:0] req_interval_end,
   input  logic        req_last_interval,
   input  logic [9:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic        rsp_feasible,
   output logic [1:0]  rsp_owner,
   output logic [10:0] rsp_set_size
);
   import tria_pkg::*;

   cmd_type    cmd;
   status_type status;

   tria_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_last_interval(req_last_interval),
      .status(status), .cmd(cmd)
   );

   tria_dpath #(.MAX_INTERVALS(MAX_INTERVALS), .TIME_BITS(TIME_BITS)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_interval_start(req_interval_start), .req_interval_end(req_interval_end),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_feasible(rsp_feasible), .rsp_owner(rsp_owner), .rsp_set_size(rsp_set_size)
   );
endmodule

[design/tria_ram.sv]
// generic single-write, single-read ram with registered read
module tria_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[design/tria_ctrl.sv]
// controller state machine for load, greedy scans and reads
module tria_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic                req_last_interval,
   input  tria_pkg::status_type status,
   output tria_pkg::cmd_type    cmd
);
   import tria_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INIT    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_TAIL    = 3'd3;
   localparam logic [2:0] S_COMMIT  = 3'd4;
   localparam logic [2:0] S_VERDICT = 3'd5;
   localparam logic [2:0] S_READ    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_stall = !(state_ff == S_IDLE && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_mode == MODE_LOAD) begin
               cmd.load = 1'b1;
               if (req_last_interval) state_in = S_INIT;
            end else if (accept) begin
               cmd.read_issue = 1'b1;
               state_in       = S_READ;
            end
         end
         S_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) state_in = S_TAIL;
         end
         S_TAIL: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (status.found) begin
               cmd.commit_assign = 1'b1;
               state_in          = S_INIT;
            end else if (!status.second) begin
               cmd.next_resource = 1'b1;
               state_in          = S_INIT;
            end else begin
               state_in = S_VERDICT;
            end
         end
         S_VERDICT: begin
            if (status.out_free) begin
               cmd.emit_verdict = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_READ: begin
            if (status.out_free) begin
               cmd.emit_read = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[design/tria_dpath.sv]
// datapath: interval stores, selection scan, owner store and result register
module tria_dpath #(
   parameter int MAX_INTERVALS = 1024,
   parameter int TIME_BITS     = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  tria_pkg::cmd_type    cmd,
   output tria_pkg::status_type status,
   input  logic [15:0]         req_interval_start,
   input  logic [15:0]         req_interval_end,
   input  logic [9:0]          req_read_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic                rsp_feasible,
   output logic [1:0]          rsp_owner,
   output logic [10:0]         rsp_set_size
);
   import tria_pkg::*;

   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int IW = (CW > 10) ? CW : 10;

   logic [CW-1:0]        count_ff, count_in, eff_count, assigned_ff;
   logic                 set_done_ff, feasible_ff, stored;
   logic [AW-1:0]        scan_addr_ff, eval_idx_ff;
   logic                 vld_ff, found_ff, have_ff, second_ff, idx_ok_ff;
   logic [TIME_BITS-1:0] best_s_ff, best_e_ff, last_s_ff, last_e_ff, chain_ff;
   logic [AW-1:0]        best_i_ff, last_i_ff;
   logic [TIME_BITS-1:0] cs, ce;
   logic [1:0]           co;
   logic                 eligible, beats;
   logic [IW-1:0]        idx_w;
   logic                 own_we, own_re;
   logic [AW-1:0]        own_waddr, own_raddr;
   logic [1:0]           own_wdata;
   logic                 rsp_valid_ff, rsp_kind_ff, rsp_feas_ff;
   logic [1:0]           rsp_owner_ff;
   logic [10:0]          rsp_size_ff;

   assign eff_count = set_done_ff ? '0 : count_ff;
   assign stored    = cmd.load && (eff_count < CW'(MAX_INTERVALS));
   assign count_in  = stored ? eff_count + CW'(1) : eff_count;
   assign idx_w     = IW'(req_read_index);

   tria_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_INTERVALS)) u_start (
      .clock(clock), .we(stored), .waddr(AW'(eff_count)),
      .wdata(TIME_BITS'(req_interval_start)),
      .re(cmd.scan_issue), .raddr(scan_addr_ff), .rdata(cs)
   );
   tria_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_INTERVALS)) u_end (
      .clock(clock), .we(stored), .waddr(AW'(eff_count)),
      .wdata(TIME_BITS'(req_interval_end)),
      .re(cmd.scan_issue), .raddr(scan_addr_ff), .rdata(ce)
   );

   assign own_we    = stored || cmd.commit_assign;
   assign own_waddr = cmd.commit_assign ? best_i_ff : AW'(eff_count);
   assign own_wdata = cmd.commit_assign ? (second_ff ? OWNER_SECOND : OWNER_FIRST)
                                        : OWNER_NONE;
   assign own_re    = cmd.scan_issue || cmd.read_issue;
   assign own_raddr = cmd.read_issue ? AW'(idx_w) : scan_addr_ff;

   tria_ram #(.WIDTH(2), .DEPTH(MAX_INTERVALS)) u_owner (
      .clock(clock), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
      .re(own_re), .raddr(own_raddr), .rdata(co)
   );

   // candidate must be free and, once this resource has a pick, fit the chain and lie past the last pick
   assign eligible = (co == OWNER_NONE) &&
      (!have_ff || ((cs >= chain_ff) &&
         ((cs > last_s_ff) || (cs == last_s_ff && ce > last_e_ff) ||
          (cs == last_s_ff && ce == last_e_ff && eval_idx_ff > last_i_ff))));
   assign beats = !found_ff || (cs < best_s_ff) ||
      (cs == best_s_ff && ce < best_e_ff) ||
      (cs == best_s_ff && ce == best_e_ff && eval_idx_ff < best_i_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         assigned_ff  <= '0;
         set_done_ff  <= 1'b0;
         feasible_ff  <= 1'b0;
         vld_ff       <= 1'b0;
         found_ff     <= 1'b0;
         have_ff      <= 1'b0;
         second_ff    <= 1'b0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff <= cmd.scan_issue;
         if (cmd.load) begin
            count_ff    <= count_in;
            set_done_ff <= 1'b0;
            feasible_ff <= 1'b0;
            assigned_ff <= '0;
            have_ff     <= 1'b0;
            second_ff   <= 1'b0;
            chain_ff    <= '0;
         end
         if (cmd.scan_init) begin
            found_ff <= 1'b0;
         end else if (vld_ff && eligible && beats) begin
            found_ff <= 1'b1;
         end
         if (cmd.commit_assign) begin
            have_ff     <= 1'b1;
            chain_ff    <= best_e_ff;
            assigned_ff <= assigned_ff + CW'(1);
         end
         if (cmd.next_resource) begin
            second_ff <= 1'b1;
            have_ff   <= 1'b0;
            chain_ff  <= '0;
         end
         if (cmd.emit_verdict) begin
            set_done_ff <= 1'b1;
            feasible_ff <= (assigned_ff == count_ff);
         end
         if (cmd.emit_verdict || cmd.emit_read) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_issue) begin
         scan_addr_ff <= scan_addr_ff + AW'(1);
      end
      eval_idx_ff <= scan_addr_ff;
      if (vld_ff && eligible && beats && !cmd.scan_init) begin
         best_s_ff <= cs;
         best_e_ff <= ce;
         best_i_ff <= eval_idx_ff;
      end
      if (cmd.commit_assign) begin
         last_s_ff <= best_s_ff;
         last_e_ff <= best_e_ff;
         last_i_ff <= best_i_ff;
      end
      if (cmd.read_issue) begin
         idx_ok_ff <= (idx_w < IW'(count_ff));
      end
      if (cmd.emit_verdict) begin
         rsp_kind_ff  <= KIND_VERDICT;
         rsp_feas_ff  <= (assigned_ff == count_ff);
         rsp_owner_ff <= OWNER_FIRST;
         rsp_size_ff  <= 11'(count_ff);
      end else if (cmd.emit_read) begin
         rsp_kind_ff  <= KIND_READ;
         rsp_feas_ff  <= set_done_ff && feasible_ff;
         rsp_owner_ff <= (set_done_ff && idx_ok_ff) ? co : OWNER_NONE;
         rsp_size_ff  <= 11'(count_ff);
      end
   end

   assign status.scan_last = (CW'(scan_addr_ff) + CW'(1) == count_ff);
   assign status.found     = found_ff;
   assign status.second    = second_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_feasible = rsp_feas_ff;
   assign rsp_owner    = rsp_owner_ff;
   assign rsp_set_size = rsp_size_ff;
endmodule
